### rtl/mtrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtrf_pkg;

	// Sizing
	localparam int COLUMNS     = 1024;
	localparam int HIST_BINS   = 1024;
	localparam int TOKEN_BYTES = 8;
	localparam int COUNT_WIDTH = 32;
	localparam int POS_W       = 10;
	localparam int Q_DEPTH     = 4;
	localparam int Q_AW        = $clog2(Q_DEPTH);
	localparam int Q_CW        = $clog2(Q_DEPTH + 1);

	localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};
	localparam logic [7:0]       SPACE   = 8'h20;

	// Opcodes
	localparam logic [2:0] OP_DATA  = 3'd0;
	localparam logic [2:0] OP_RCOL  = 3'd1;
	localparam logic [2:0] OP_RHIST = 3'd2;
	localparam logic [2:0] OP_CLR   = 3'd3;
	localparam logic [2:0] OP_RRWM  = 3'd4;

	// Event kinds, front to back
	localparam logic [2:0] EV_UPD   = 3'd0;
	localparam logic [2:0] EV_RCOL  = 3'd1;
	localparam logic [2:0] EV_RHIST = 3'd2;
	localparam logic [2:0] EV_RRWM  = 3'd3;
	localparam logic [2:0] EV_CLR   = 3'd4;

	// Result kinds
	localparam logic RK_VERDICT = 1'b0;
	localparam logic RK_READ    = 1'b1;

	// Register indexes
	localparam logic [2:0] REG_MISSING_TOKEN = 3'd0;
	localparam logic [2:0] REG_TOKEN_LENGTH  = 3'd1;
	localparam logic [2:0] REG_EXPECTED_COLS = 3'd2;
	localparam logic [2:0] REG_MAX_OK        = 3'd3;
	localparam logic [2:0] REG_FILTER_EN     = 3'd4;
	localparam logic [2:0] REG_RECTANGULAR   = 3'd5;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
		logic       record_end;
		logic [9:0] read_index;
	} in_t;

	typedef struct packed {
		logic        result_kind;
		logic [9:0]  missing_count;
		logic        keep_record;
		logic        column_mismatch;
		logic [9:0]  columns_seen;
		logic [31:0] read_value;
	} out_t;

	typedef struct packed {
		logic [63:0] missing_token;
		logic [3:0]  token_length;
		logic [10:0] expected_columns;
		logic [10:0] max_ok_missing;
		logic        filter_enable;
		logic        require_rectangular;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic             col_en;
		logic [POS_W-1:0] col_addr;
		logic             hist_en;
		logic [POS_W-1:0] hist_bin;
		logic             rwm_inc;
		logic             verdict_en;
		logic [POS_W-1:0] missing_count;
		logic             keep_record;
		logic             column_mismatch;
		logic [POS_W-1:0] columns_seen;
	} ev_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	// Mask of the low n bytes of a 64-bit word
	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n) begin
				m[8*i +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

### rtl/missing_token_record_filter.sv
// Missing-token record filter.
// Input queue side: item carries one byte of space-separated text (opcode 0)
// or a statistics command (read column count, read histogram bin, clear,
// read count of records with missing values and no column mismatch).
// A transaction is taken on a rising edge with push high and full low; one
// per cycle is sustained while full is low. Result queue side: while empty
// is low, result holds the oldest record verdict or read reply; pop high
// with empty low takes it. A byte that ends a record and every read produce
// exactly one result; other bytes, clear and unused opcodes produce none.
// Transactions pass the event queue, execute stage and result queue. The
// front tokeniser and the back counter engine are decoupled by a four-entry
// event queue; the back end reads and rewrites its counter memories in two
// stages with a bypass, so one event per cycle goes through while the result
// queue has room and no clear or sweep runs. A stalled receiver fills the
// four-entry result queue, then the event queue, and then full rises; nothing
// is lost. Reset and clear: both counter memories (1024 entries each) are
// zeroed by a sweep, one entry a cycle; full stays high meanwhile.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module missing_token_record_filter import mtrf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input queue
	input  wire logic        push,
	output logic             full,
	input  wire in_t         item,
	// Result queue
	output logic             empty,
	input  wire logic        pop,
	output out_t             result,
	// Configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	cfg_t cfg_q;
	logic accept;
	logic ev_valid;
	ev_t  ev;
	ev_t  q_head;
	logic q_avail;
	logic q_full;
	logic q_pop;
	logic sweeping;

	// Register file; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.missing_token       <= 64'd46;
			cfg_q.token_length        <= 4'd1;
			cfg_q.expected_columns    <= 11'd1024;
			cfg_q.max_ok_missing      <= 11'd0;
			cfg_q.filter_enable       <= 1'b0;
			cfg_q.require_rectangular <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MISSING_TOKEN: cfg_q.missing_token       <= cfg_data;
				REG_TOKEN_LENGTH:  cfg_q.token_length        <= cfg_data[3:0];
				REG_EXPECTED_COLS: cfg_q.expected_columns    <= cfg_data[10:0];
				REG_MAX_OK:        cfg_q.max_ok_missing      <= cfg_data[10:0];
				REG_FILTER_EN:     cfg_q.filter_enable       <= cfg_data[0];
				REG_RECTANGULAR:   cfg_q.require_rectangular <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// No transaction is taken while the counter memories are being cleared
	assign full   = q_full || sweeping;
	assign accept = push && !full;

	// Front: tokenises bytes and turns each transaction into at most one event
	mtrf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.item     (item),
		.accept   (accept),
		.ev_valid (ev_valid),
		.ev       (ev)
	);

	mtrf_ev_queue u_ev_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept && ev_valid),
		.wdata  (ev),
		.rd     (q_pop),
		.head   (q_head),
		.avail  (q_avail),
		.q_full (q_full)
	);

	// Back: counter memories, read replies and the result queue
	mtrf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_head   (q_head),
		.q_avail  (q_avail),
		.q_pop    (q_pop),
		.sweeping (sweeping),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

### rtl/mtrf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mtrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/mtrf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mtrf_front import mtrf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire in_t  item,
	input  wire logic accept,
	output logic      ev_valid,
	output ev_t       ev
);

	logic [63:0]      bytes_q;
	logic [3:0]       fill_q;
	logic             over_q;
	logic             inside_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] miss_q;

	logic             is_sp;
	logic [63:0]      bytes_a;
	logic [3:0]       fill_a;
	logic             over_a;
	logic [63:0]      bytes_t;
	logic [3:0]       fill_t;
	logic             over_t;
	logic             do_close;
	logic             tl_ok;
	logic             match;
	logic             hit;
	logic [POS_W-1:0] miss_n;
	logic [POS_W-1:0] pos_n;
	logic             col_en;
	logic             mismatch;
	logic             keep;
	logic             is_data;

	assign is_data = (item.opcode == OP_DATA);
	assign is_sp   = (item.data_byte == SPACE);

	// Token after taking a non-space byte
	always_comb begin
		bytes_a = bytes_q;
		fill_a  = fill_q;
		over_a  = over_q;
		if (!inside_q) begin
			bytes_a = 64'(item.data_byte);
			fill_a  = 4'd1;
			over_a  = 1'b0;
		end else if (fill_q < 4'(TOKEN_BYTES)) begin
			bytes_a = bytes_q | (64'(item.data_byte) << {fill_q[2:0], 3'b000});
			fill_a  = fill_q + 4'd1;
		end else begin
			over_a = 1'b1;
		end
	end

	assign bytes_t  = is_sp ? bytes_q : bytes_a;
	assign fill_t   = is_sp ? fill_q : fill_a;
	assign over_t   = is_sp ? over_q : over_a;
	assign do_close = is_sp ? inside_q : item.record_end;

	assign tl_ok = (cfg.token_length inside {[4'd1:4'(TOKEN_BYTES)]});
	assign match = !over_t && tl_ok && (fill_t == cfg.token_length) &&
		(bytes_t == (cfg.missing_token & byte_mask(fill_t)));

	// The id column is never examined
	assign hit    = do_close && (pos_q != '0) && match;
	assign miss_n = (hit && miss_q != POS_SAT) ? miss_q + POS_W'(1) : miss_q;
	assign pos_n  = (do_close && pos_q != POS_SAT) ? pos_q + POS_W'(1) : pos_q;
	assign col_en = hit && (pos_q != POS_SAT) && (int'(pos_q) < COLUMNS);

	assign mismatch = cfg.require_rectangular && ({1'b0, pos_n} != cfg.expected_columns);
	assign keep     = !cfg.filter_enable || ({1'b0, miss_n} <= cfg.max_ok_missing);

	always_comb begin
		ev          = '0;
		ev_valid    = 1'b0;
		ev.col_addr = item.read_index;
		ev.hist_bin = item.read_index;
		case (item.opcode)
			OP_DATA: begin
				ev.kind            = EV_UPD;
				ev_valid           = col_en || item.record_end;
				ev.col_en          = col_en;
				ev.col_addr        = pos_q;
				ev.verdict_en      = item.record_end;
				ev.hist_en         = item.record_end && (miss_n != '0);
				ev.hist_bin        = miss_n;
				ev.rwm_inc         = !mismatch;
				ev.missing_count   = miss_n;
				ev.keep_record     = keep;
				ev.column_mismatch = mismatch;
				ev.columns_seen    = pos_n;
			end
			OP_RCOL: begin
				ev.kind  = EV_RCOL;
				ev_valid = 1'b1;
			end
			OP_RHIST: begin
				ev.kind  = EV_RHIST;
				ev_valid = 1'b1;
			end
			OP_CLR: begin
				ev.kind  = EV_CLR;
				ev_valid = 1'b1;
			end
			OP_RRWM: begin
				ev.kind  = EV_RRWM;
				ev_valid = 1'b1;
			end
			default: begin
				ev_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q  <= '0;
			fill_q   <= '0;
			over_q   <= 1'b0;
			inside_q <= 1'b0;
			pos_q    <= '0;
			miss_q   <= '0;
		end else if (accept && is_data) begin
			if (do_close) begin
				bytes_q  <= '0;
				fill_q   <= '0;
				over_q   <= 1'b0;
				inside_q <= 1'b0;
			end else if (!is_sp) begin
				bytes_q  <= bytes_a;
				fill_q   <= fill_a;
				over_q   <= over_a;
				inside_q <= 1'b1;
			end
			if (item.record_end) begin
				pos_q  <= '0;
				miss_q <= '0;
			end else begin
				pos_q  <= pos_n;
				miss_q <= miss_n;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/mtrf_ev_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mtrf_ev_queue import mtrf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire ev_t  wdata,
	input  wire logic rd,
	output ev_t       head,
	output logic      avail,
	output logic      q_full
);

	ev_t             mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_CW-1:0] cnt_q;

	assign head   = mem_q[rp_q];
	assign avail  = (cnt_q != '0);
	assign q_full = (cnt_q == Q_CW'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + Q_AW'(1);
			end
			if (rd) begin
				rp_q <= rp_q + Q_AW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + Q_CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - Q_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/mtrf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mtrf_back import mtrf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ev_t  q_head,
	input  wire logic q_avail,
	output logic      q_pop,
	output logic      sweeping,
	output logic      empty,
	input  wire logic pop,
	output out_t      result
);

	localparam int HA = $clog2(HIST_BINS);

	// Clearing sweep
	logic             sweep_q;
	logic [POS_W-1:0] sweep_addr_q;

	// Execute stage
	logic             exec_v_s1;
	ev_t              exec_s1;

	// Memories and bypass of the last write
	logic [COUNT_WIDTH-1:0] col_rdata;
	logic [COUNT_WIDTH-1:0] hist_rdata;
	logic                   byp_col_v_q;
	logic [POS_W-1:0]       byp_col_a_q;
	logic [COUNT_WIDTH-1:0] byp_col_d_q;
	logic                   byp_hist_v_q;
	logic [HA-1:0]          byp_hist_a_q;
	logic [COUNT_WIDTH-1:0] byp_hist_d_q;
	logic [COUNT_WIDTH-1:0] rwm_q;

	logic [COUNT_WIDTH-1:0] col_cur;
	logic [COUNT_WIDTH-1:0] hist_cur;
	logic [COUNT_WIDTH-1:0] col_new;
	logic [COUNT_WIDTH-1:0] hist_new;
	logic                   col_we_x;
	logic                   hist_we_x;
	logic                   col_we;
	logic [POS_W-1:0]       col_waddr;
	logic [COUNT_WIDTH-1:0] col_wdata;
	logic                   hist_we;
	logic [HA-1:0]          hist_waddr;
	logic [COUNT_WIDTH-1:0] hist_wdata;
	logic                   exec_clr;

	// Result queue
	out_t            oq_q [Q_DEPTH];
	logic [Q_AW-1:0] owp_q;
	logic [Q_AW-1:0] orp_q;
	logic [Q_CW-1:0] oc_q;
	logic            res_v;
	out_t            res;
	logic            res_pop;

	assign exec_clr = exec_v_s1 && (exec_s1.kind == EV_CLR);
	assign sweeping = sweep_q;

	// Room is reserved for the transaction in flight
	assign q_pop = q_avail && !sweep_q && !exec_clr &&
		(({1'b0, oc_q} + (Q_CW + 1)'(exec_v_s1)) < (Q_CW + 1)'(Q_DEPTH));

	mtrf_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(COLUMNS)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.raddr (q_head.col_addr),
		.rdata (col_rdata)
	);

	mtrf_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(HIST_BINS)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (q_head.hist_bin),
		.rdata (hist_rdata)
	);

	assign col_cur  = (byp_col_v_q && byp_col_a_q == exec_s1.col_addr) ? byp_col_d_q : col_rdata;
	assign hist_cur = (byp_hist_v_q && byp_hist_a_q == exec_s1.hist_bin) ? byp_hist_d_q :
		hist_rdata;
	assign col_new  = sat_inc(col_cur);
	assign hist_new = sat_inc(hist_cur);

	assign col_we_x  = exec_v_s1 && (exec_s1.kind == EV_UPD) && exec_s1.col_en;
	assign hist_we_x = exec_v_s1 && (exec_s1.kind == EV_UPD) && exec_s1.hist_en;

	assign col_we     = sweep_q || col_we_x;
	assign col_waddr  = sweep_q ? sweep_addr_q : exec_s1.col_addr;
	assign col_wdata  = sweep_q ? '0 : col_new;
	assign hist_we    = sweep_q || hist_we_x;
	assign hist_waddr = sweep_q ? sweep_addr_q : exec_s1.hist_bin;
	assign hist_wdata = sweep_q ? '0 : hist_new;

	always_comb begin
		res   = '0;
		res_v = 1'b0;
		case (exec_s1.kind)
			EV_UPD: begin
				res_v                = exec_v_s1 && exec_s1.verdict_en;
				res.result_kind      = RK_VERDICT;
				res.missing_count    = exec_s1.missing_count;
				res.keep_record      = exec_s1.keep_record;
				res.column_mismatch  = exec_s1.column_mismatch;
				res.columns_seen     = exec_s1.columns_seen;
			end
			EV_RCOL: begin
				res_v           = exec_v_s1;
				res.result_kind = RK_READ;
				res.read_value  = col_cur;
			end
			EV_RHIST: begin
				res_v           = exec_v_s1;
				res.result_kind = RK_READ;
				res.read_value  = hist_cur;
			end
			EV_RRWM: begin
				res_v           = exec_v_s1;
				res.result_kind = RK_READ;
				res.read_value  = rwm_q;
			end
			default: begin
				res_v = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			exec_s1 <= q_head;
		end
		byp_col_a_q  <= exec_s1.col_addr;
		byp_col_d_q  <= col_new;
		byp_hist_a_q <= exec_s1.hist_bin;
		byp_hist_d_q <= hist_new;
		if (res_v) begin
			oq_q[owp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			exec_v_s1    <= 1'b0;
			byp_col_v_q  <= 1'b0;
			byp_hist_v_q <= 1'b0;
			rwm_q        <= '0;
		end else begin
			exec_v_s1    <= q_pop;
			byp_col_v_q  <= col_we_x;
			byp_hist_v_q <= hist_we_x;
			if (sweep_q) begin
				sweep_addr_q <= sweep_addr_q + POS_W'(1);
				if (sweep_addr_q == POS_SAT) begin
					sweep_q <= 1'b0;
				end
			end else if (exec_clr) begin
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
			end
			if (exec_clr) begin
				rwm_q <= '0;
			end else if (hist_we_x && exec_s1.rwm_inc) begin
				rwm_q <= sat_inc(rwm_q);
			end
		end
	end

	assign empty   = (oc_q == '0);
	assign res_pop = pop && !empty;
	assign result  = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= '0;
			orp_q <= '0;
			oc_q  <= '0;
		end else begin
			if (res_v) begin
				owp_q <= owp_q + Q_AW'(1);
			end
			if (res_pop) begin
				orp_q <= orp_q + Q_AW'(1);
			end
			if (res_v && !res_pop) begin
				oc_q <= oc_q + Q_CW'(1);
			end else if (res_pop && !res_v) begin
				oc_q <= oc_q - Q_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire
